// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the stride classifier checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stride classifier check failed");

// Next-cycle implication, disabled during reset.
`define ASC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stride classifier check failed");

`endif

// ===== sv/asc_pkg.sv =====
// ----------------------------------------------------------------------------
// asc_pkg
// Types and fixed constants of the address stride classifier.
// ----------------------------------------------------------------------------
package asc_pkg;

   localparam int unsigned ADDR_W  = 32;
   localparam int unsigned CNT_W   = 32;
   localparam int unsigned SUM_W   = 64;
   localparam int unsigned LIMIT_W = 13;
   localparam int unsigned BIN_W   = 8;

   localparam logic [LIMIT_W-1:0] SEQ_LIMIT_RESET    = 13'd64;
   localparam logic [LIMIT_W-1:0] STRIDE_LIMIT_RESET = 13'd4096;

   // Register indexes on the csr port
   localparam logic CSR_SEQ_LIMIT    = 1'b0;
   localparam logic CSR_STRIDE_LIMIT = 1'b1;

   typedef enum logic [1:0] {
      CMD_ACCESS   = 2'd0,
      CMD_READ_BIN = 2'd1,
      CMD_CLEAR    = 2'd2,
      CMD_NOP      = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CLASS_NONE       = 2'd0,
      CLASS_SEQUENTIAL = 2'd1,
      CLASS_STRIDED    = 2'd2,
      CLASS_RANDOM     = 2'd3
   } class_type;

endpackage

// ===== sv/address_stride_classifier.sv =====
// ----------------------------------------------------------------------------
// address_stride_classifier
// Classifies consecutive access addresses by stride, keeps running totals
// and a stride histogram in a single-port-write block RAM.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  req     | in        | req_valid/ready    | command, address, bin_index
//  rsp     | out       | rsp_valid/ready    | class, stride, hit, distance,
//          |           |                    | totals, distance_sum, bin_value
//  csr     | in        | csr_write_en       | csr_index, csr_write_data
//
//  - One item per cycle unless rsp stalls or a clear or sweep is pending;
//    stage 1 subtract, stage 2 histogram read-modify-write, output register.
//  - Histogram bins are read through a registered port; a write in stage 2
//    to the bin the next item is reading is forwarded.
//  - After reset, and after a clear item leaves stage 2, a sweep zeroes the
//    HIST_BINS histogram entries, one per cycle; req_ready stays low while
//    the sweep runs.
//  - A stalled rsp holds the output register; stages behind it fill, then
//    req_ready drops.
//
module address_stride_classifier #(
   parameter int unsigned HIST_BINS  = 256,
   parameter int unsigned LINE_SHIFT = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   // request
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_command,
   input  logic [asc_pkg::ADDR_W-1:0]        req_address,
   input  logic [asc_pkg::BIN_W-1:0]         req_bin_index,
   // response
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_pattern_class,
   output logic signed [asc_pkg::ADDR_W-1:0] rsp_stride_value,
   output logic                              rsp_spatial_hit,
   output logic [asc_pkg::ADDR_W-1:0]        rsp_distance,
   output logic [asc_pkg::CNT_W-1:0]         rsp_sequential_total,
   output logic [asc_pkg::CNT_W-1:0]         rsp_strided_total,
   output logic [asc_pkg::CNT_W-1:0]         rsp_spatial_total,
   output logic [asc_pkg::CNT_W-1:0]         rsp_pair_total,
   output logic [asc_pkg::SUM_W-1:0]         rsp_distance_sum,
   output logic [asc_pkg::CNT_W-1:0]         rsp_bin_value,
   // configuration
   input  logic                              csr_write_en,
   input  logic                              csr_index,
   input  logic [asc_pkg::LIMIT_W-1:0]       csr_write_data
);

   localparam int unsigned AW      = $clog2(HIST_BINS);
   localparam int unsigned BW      = asc_pkg::ADDR_W - LINE_SHIFT;
   localparam int unsigned HALF    = HIST_BINS / 2;
   localparam int unsigned UPPER   = HIST_BINS - HALF;
   localparam logic [AW-1:0] HALF_A = AW'(HALF);
   localparam logic [AW-1:0] LAST_A = AW'(HIST_BINS - 1);

   function automatic logic [asc_pkg::CNT_W-1:0] sat_inc(
      input logic [asc_pkg::CNT_W-1:0] v
   );
      sat_inc = (&v) ? v : v + 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // Configuration
   // ------------------------------------------------------------------------
   logic [asc_pkg::LIMIT_W-1:0] seq_limit_ff;
   logic [asc_pkg::LIMIT_W-1:0] stride_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_limit_ff    <= asc_pkg::SEQ_LIMIT_RESET;
         stride_limit_ff <= asc_pkg::STRIDE_LIMIT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            asc_pkg::CSR_SEQ_LIMIT:    seq_limit_ff    <= csr_write_data;
            asc_pkg::CSR_STRIDE_LIMIT: stride_limit_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Pipeline control
   // ------------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, out_valid_ff;
   logic s1_adv, s2_adv, req_accept;
   logic sweep_active_ff;
   logic [AW-1:0] sweep_addr_ff;
   asc_pkg::cmd_type s1_cmd_ff, s2_cmd_ff;
   logic clear_in_flight;

   assign s2_adv = s2_valid_ff && (!out_valid_ff || rsp_ready);
   assign s1_adv = s1_valid_ff && (!s2_valid_ff || s2_adv);

   // A clear blocks new items until its sweep has finished.
   assign clear_in_flight = (s1_valid_ff && s1_cmd_ff == asc_pkg::CMD_CLEAR) ||
                            (s2_valid_ff && s2_cmd_ff == asc_pkg::CMD_CLEAR);
   assign req_ready  = (!s1_valid_ff || s1_adv) && !sweep_active_ff && !clear_in_flight;
   assign req_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_accept)  s1_valid_ff <= 1'b1;
         else if (s1_adv) s1_valid_ff <= 1'b0;
         if (s1_adv)      s2_valid_ff <= 1'b1;
         else if (s2_adv) s2_valid_ff <= 1'b0;
         if (s2_adv)         out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
      end
   end

   // Histogram clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_active_ff <= 1'b1;
         sweep_addr_ff   <= '0;
      end else if (sweep_active_ff) begin
         sweep_addr_ff <= sweep_addr_ff + 1'b1;
         if (sweep_addr_ff == LAST_A) begin
            sweep_active_ff <= 1'b0;
         end
      end else if (s2_adv && s2_cmd_ff == asc_pkg::CMD_CLEAR) begin
         sweep_active_ff <= 1'b1;
         sweep_addr_ff   <= '0;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: previous address, raw stride and block difference
   // ------------------------------------------------------------------------
   logic [asc_pkg::ADDR_W-1:0] prev_addr_ff;
   logic                       have_prev_ff;
   logic                       s1_pair_ff;
   logic [asc_pkg::ADDR_W-1:0] s1_stride_ff;
   logic [BW-1:0]              s1_blk_ff;
   logic [asc_pkg::BIN_W-1:0]  s1_bin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_addr_ff <= '0;
         have_prev_ff <= 1'b0;
         s1_cmd_ff    <= asc_pkg::CMD_NOP;
      end else if (req_accept) begin
         s1_cmd_ff <= asc_pkg::cmd_type'(req_command);
         if (req_command == asc_pkg::CMD_ACCESS) begin
            prev_addr_ff <= req_address;
            have_prev_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pair_ff   <= have_prev_ff && (req_command == asc_pkg::CMD_ACCESS);
         s1_stride_ff <= req_address - prev_addr_ff;
         // block number difference; wraps like the address
         s1_blk_ff    <= req_address[asc_pkg::ADDR_W-1:LINE_SHIFT]
                         - prev_addr_ff[asc_pkg::ADDR_W-1:LINE_SHIFT];
         s1_bin_ff    <= req_bin_index;
      end
   end

   // Stage 1 decode: distance, class, histogram bin
   logic                       s1_neg;
   logic [asc_pkg::ADDR_W-1:0] s1_dist;
   logic [BW-1:0]              s1_q;
   logic                       s1_line_aligned;
   logic                       s1_in_range;
   logic [AW-1:0]              s1_idx;
   logic                       s1_hit;
   logic                       s1_bin_ok;
   logic [asc_pkg::ADDR_W-1:0] s1_bin_ext;
   logic [AW-1:0]              rd_addr;
   asc_pkg::class_type         s1_class;

   always_comb begin
      s1_neg          = s1_stride_ff[asc_pkg::ADDR_W-1];
      s1_dist         = s1_neg ? ('0 - s1_stride_ff) : s1_stride_ff;
      s1_q            = s1_dist[asc_pkg::ADDR_W-1:LINE_SHIFT];
      s1_line_aligned = (s1_stride_ff[LINE_SHIFT-1:0] == '0);
      s1_in_range     = s1_neg ? (asc_pkg::ADDR_W'(s1_q) <= asc_pkg::ADDR_W'(HALF))
                               : (asc_pkg::ADDR_W'(s1_q) <  asc_pkg::ADDR_W'(UPPER));
      s1_idx          = s1_neg ? (HALF_A - s1_q[AW-1:0]) : (HALF_A + s1_q[AW-1:0]);
      s1_hit          = (s1_blk_ff == '0) || (s1_blk_ff == BW'(1)) || (&s1_blk_ff);

      if (!s1_pair_ff) begin
         s1_class = asc_pkg::CLASS_NONE;
      end else if (s1_dist <= asc_pkg::ADDR_W'(seq_limit_ff)) begin
         s1_class = asc_pkg::CLASS_SEQUENTIAL;
      end else if (s1_dist <= asc_pkg::ADDR_W'(stride_limit_ff) && s1_line_aligned) begin
         s1_class = asc_pkg::CLASS_STRIDED;
      end else begin
         s1_class = asc_pkg::CLASS_RANDOM;
      end

      s1_bin_ext = asc_pkg::ADDR_W'(s1_bin_ff);
      s1_bin_ok  = s1_bin_ext < asc_pkg::ADDR_W'(HIST_BINS);
      rd_addr    = (s1_cmd_ff == asc_pkg::CMD_READ_BIN) ? s1_bin_ext[AW-1:0] : s1_idx;
   end

   // ------------------------------------------------------------------------
   // Histogram memory: read on stage 1 -> 2, write on stage 2 -> output
   // ------------------------------------------------------------------------
   logic [asc_pkg::CNT_W-1:0] hist_mem [HIST_BINS];
   logic [asc_pkg::CNT_W-1:0] mem_q_ff;
   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic [asc_pkg::CNT_W-1:0] wr_data;
   logic                      fwd_hit_ff;
   logic [asc_pkg::CNT_W-1:0] fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         mem_q_ff <= hist_mem[rd_addr];
      end
   end

   // Same-edge write to the bin being read: take the written value instead.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (s1_adv) begin
         fwd_hit_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         fwd_data_ff <= wr_data;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: counters, bin increment, result
   // ------------------------------------------------------------------------
   asc_pkg::class_type         s2_class_ff;
   logic [asc_pkg::ADDR_W-1:0] s2_stride_ff;
   logic [asc_pkg::ADDR_W-1:0] s2_dist_ff;
   logic                       s2_hit_ff;
   logic                       s2_inc_ff;
   logic                       s2_bin_ok_ff;
   logic [AW-1:0]              s2_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_cmd_ff   <= asc_pkg::CMD_NOP;
         s2_class_ff <= asc_pkg::CLASS_NONE;
      end else if (s1_adv) begin
         s2_cmd_ff   <= s1_cmd_ff;
         s2_class_ff <= s1_class;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_stride_ff <= s1_pair_ff ? s1_stride_ff : '0;
         s2_dist_ff   <= s1_pair_ff ? s1_dist : '0;
         s2_hit_ff    <= s1_pair_ff && s1_hit;
         s2_inc_ff    <= (s1_class == asc_pkg::CLASS_STRIDED) && s1_in_range;
         s2_bin_ok_ff <= s1_bin_ok;
         s2_addr_ff   <= rd_addr;
      end
   end

   logic [asc_pkg::CNT_W-1:0] hist_rd;
   logic                      s2_pair;

   assign hist_rd = fwd_hit_ff ? fwd_data_ff : mem_q_ff;
   assign s2_pair = (s2_class_ff != asc_pkg::CLASS_NONE);

   // Sweep owns the write port while the pipeline is empty.
   always_comb begin
      if (sweep_active_ff) begin
         wr_en   = 1'b1;
         wr_addr = sweep_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = s2_adv && s2_inc_ff;
         wr_addr = s2_addr_ff;
         wr_data = sat_inc(hist_rd);
      end
   end

   // Running totals
   logic [asc_pkg::CNT_W-1:0] seq_cnt_ff,    seq_cnt_in;
   logic [asc_pkg::CNT_W-1:0] strd_cnt_ff,   strd_cnt_in;
   logic [asc_pkg::CNT_W-1:0] spat_cnt_ff,   spat_cnt_in;
   logic [asc_pkg::CNT_W-1:0] pair_cnt_ff,   pair_cnt_in;
   logic [asc_pkg::SUM_W-1:0] dist_sum_ff,   dist_sum_in;

   always_comb begin
      seq_cnt_in  = seq_cnt_ff;
      strd_cnt_in = strd_cnt_ff;
      spat_cnt_in = spat_cnt_ff;
      pair_cnt_in = pair_cnt_ff;
      dist_sum_in = dist_sum_ff;
      if (s2_cmd_ff == asc_pkg::CMD_CLEAR) begin
         seq_cnt_in  = '0;
         strd_cnt_in = '0;
         spat_cnt_in = '0;
         pair_cnt_in = '0;
         dist_sum_in = '0;
      end else if (s2_pair) begin
         if (s2_class_ff == asc_pkg::CLASS_SEQUENTIAL) seq_cnt_in  = sat_inc(seq_cnt_ff);
         if (s2_class_ff == asc_pkg::CLASS_STRIDED)    strd_cnt_in = sat_inc(strd_cnt_ff);
         if (s2_hit_ff)                                spat_cnt_in = sat_inc(spat_cnt_ff);
         pair_cnt_in = sat_inc(pair_cnt_ff);
         dist_sum_in = dist_sum_ff + asc_pkg::SUM_W'(s2_dist_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_cnt_ff  <= '0;
         strd_cnt_ff <= '0;
         spat_cnt_ff <= '0;
         pair_cnt_ff <= '0;
         dist_sum_ff <= '0;
      end else if (s2_adv) begin
         seq_cnt_ff  <= seq_cnt_in;
         strd_cnt_ff <= strd_cnt_in;
         spat_cnt_ff <= spat_cnt_in;
         pair_cnt_ff <= pair_cnt_in;
         dist_sum_ff <= dist_sum_in;
      end
   end

   // ------------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------------
   logic [1:0]                 out_class_ff;
   logic [asc_pkg::ADDR_W-1:0] out_stride_ff;
   logic                       out_hit_ff;
   logic [asc_pkg::ADDR_W-1:0] out_dist_ff;
   logic [asc_pkg::CNT_W-1:0]  out_bin_ff;

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         out_class_ff  <= s2_class_ff;
         out_stride_ff <= s2_stride_ff;
         out_hit_ff    <= s2_hit_ff;
         out_dist_ff   <= s2_dist_ff;
         out_bin_ff    <= (s2_cmd_ff == asc_pkg::CMD_READ_BIN && s2_bin_ok_ff) ? hist_rd : '0;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_pattern_class    = out_class_ff;
   assign rsp_stride_value     = out_stride_ff;
   assign rsp_spatial_hit      = out_hit_ff;
   assign rsp_distance         = out_dist_ff;
   // Totals already hold this item's update once it sits in the output register.
   assign rsp_sequential_total = seq_cnt_ff;
   assign rsp_strided_total    = strd_cnt_ff;
   assign rsp_spatial_total    = spat_cnt_ff;
   assign rsp_pair_total       = pair_cnt_ff;
   assign rsp_distance_sum     = dist_sum_ff;
   assign rsp_bin_value        = out_bin_ff;

endmodule

// ===== sv/asc_checker.sv =====
// ----------------------------------------------------------------------------
// asc_checker
// Port-level checks on the classifier response channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module asc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [1:0]                        rsp_pattern_class,
   input logic signed [asc_pkg::ADDR_W-1:0] rsp_stride_value,
   input logic                              rsp_spatial_hit,
   input logic [asc_pkg::ADDR_W-1:0]        rsp_distance,
   input logic [asc_pkg::CNT_W-1:0]         rsp_bin_value
);

   // stalled result holds
   `ASC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_distance) && $stable(rsp_pattern_class))

   // no pair: stride fields all zero
   `ASC_ASSERT_IMPLY(a_none_zero, clock, reset, rsp_valid && rsp_pattern_class == asc_pkg::CLASS_NONE, rsp_stride_value == 0 && rsp_distance == 0 && !rsp_spatial_hit)

   // distance is the magnitude of the stride
   `ASC_ASSERT_IMPLY(a_dist_abs, clock, reset, rsp_valid, rsp_distance == (rsp_stride_value[31] ? (32'd0 - 32'(rsp_stride_value)) : 32'(rsp_stride_value)))

   // access results never carry a bin value
   `ASC_ASSERT_IMPLY(a_bin_only_read, clock, reset, rsp_valid && rsp_pattern_class != asc_pkg::CLASS_NONE, rsp_bin_value == 0)

   // sequential distance fits the limit register
   `ASC_ASSERT_IMPLY(a_seq_small, clock, reset, rsp_valid && rsp_pattern_class == asc_pkg::CLASS_SEQUENTIAL, (rsp_distance >> asc_pkg::LIMIT_W) == 0)

endmodule

bind address_stride_classifier asc_checker u_asc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_pattern_class (rsp_pattern_class),
   .rsp_stride_value  (rsp_stride_value),
   .rsp_spatial_hit   (rsp_spatial_hit),
   .rsp_distance      (rsp_distance),
   .rsp_bin_value     (rsp_bin_value)
);
